// File: design/rsms_pkg.sv
// Shared types and constants for the rotated sorted minimum search block.
// Used by rsms_mem, rsms_search and rotated_sorted_min_search.
package rsms_pkg;

    // Default number of elements the value store holds.
    localparam int DEPTH_DEF = 1024;
    // Width of one stored element.
    localparam int VAL_W = 32;
    // Width of the rotation field in a result item.
    localparam int ROT_W = 10;

    // One input item: an element and its end-of-array mark.
    typedef struct packed {
        logic signed [VAL_W-1:0] elem_value;
        logic                    last;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [ROT_W-1:0] rotation;
        logic             found;
    } t_out_item;

    // Search sequencer states.
    typedef enum logic [2:0] {
        S_LOAD,
        S_CHECK,
        S_RD_HI,
        S_ENDS,
        S_RD_NXT,
        S_RD_PRV,
        S_DECIDE,
        S_DONE
    } t_srch_state;

    // Status of the search sequencer toward the top level.
    typedef struct packed {
        logic busy;
        logic done;
        logic found;
    } t_srch_stat;

endpackage

// File: design/rsms_mem.sv
// Value store: one write port and one read port, read data registered.
// Depends on rsms_pkg for the element width.
module rsms_mem
    import rsms_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [VAL_W-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [VAL_W-1:0] o_rdata
);

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered: data for an address appears in the next cycle.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/rsms_search.sv
// Binary search sequencer that walks the value store through its read port.
// Depends on rsms_pkg for the state enum and the status struct.
module rsms_search
    import rsms_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1),
    localparam int IW = CW + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [CW-1:0]    i_count,
    input  logic             i_res_take,
    input  logic [VAL_W-1:0] i_rdata,
    output logic [AW-1:0]    o_raddr,
    output t_srch_stat       o_stat,
    output logic [AW-1:0]    o_where
);

    t_srch_state r_state, n_state;

    logic signed [IW-1:0]    r_lo, n_lo;
    logic signed [IW-1:0]    r_hi, n_hi;
    logic [CW-1:0]           r_count, n_count;
    logic [AW-1:0]           r_mid, n_mid;
    logic signed [VAL_W-1:0] r_vlo, n_vlo;
    logic signed [VAL_W-1:0] r_vhi, n_vhi;
    logic signed [VAL_W-1:0] r_vm, n_vm;
    logic signed [VAL_W-1:0] r_vn, n_vn;
    logic [AW-1:0]           r_where, n_where;
    logic                    r_found, n_found;

    logic signed [VAL_W-1:0] w_rd;
    logic [IW:0]             w_sum;
    logic [AW-1:0]           w_mid;
    logic [CW-1:0]           w_mid1;
    logic [CW-1:0]           w_cm1;
    logic [AW-1:0]           w_nxt;
    logic [AW-1:0]           w_prv;
    logic signed [IW-1:0]    w_mid_ext;
    logic                    w_range_ok;
    logic                    w_ends_ok;
    logic                    w_is_pivot;

    // Index arithmetic: middle of the range and its wrapped neighbors.
    assign w_rd       = $signed(i_rdata);
    assign w_sum      = {r_lo[IW-1], r_lo} + {r_hi[IW-1], r_hi};
    assign w_mid      = w_sum[AW:1];
    assign w_mid1     = CW'(r_mid) + CW'(1);
    assign w_cm1      = r_count - CW'(1);
    assign w_nxt      = (w_mid1 == r_count) ? '0 : w_mid1[AW-1:0];
    assign w_prv      = (r_mid == '0) ? w_cm1[AW-1:0] : r_mid - AW'(1);
    assign w_mid_ext  = $signed({{(IW - AW){1'b0}}, r_mid});
    assign w_range_ok = (r_lo <= r_hi);
    assign w_ends_ok  = (r_vlo <= w_rd);
    assign w_is_pivot = (r_vm <= r_vn) && (r_vm <= w_rd);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (i_start) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = w_range_ok ? S_RD_HI : S_DONE;
            end
            S_RD_HI: begin
                n_state = S_ENDS;
            end
            S_ENDS: begin
                n_state = w_ends_ok ? S_DONE : S_RD_NXT;
            end
            S_RD_NXT: begin
                n_state = S_RD_PRV;
            end
            S_RD_PRV: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                priority if (w_is_pivot) begin
                    n_state = S_DONE;
                end else if (r_vm <= r_vhi || r_vm >= r_vlo) begin
                    n_state = S_CHECK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // Read addresses and datapath updates for each state.
    always_comb begin
        o_raddr = r_lo[AW-1:0];
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_count = r_count;
        n_mid   = r_mid;
        n_vlo   = r_vlo;
        n_vhi   = r_vhi;
        n_vm    = r_vm;
        n_vn    = r_vn;
        n_where = r_where;
        n_found = r_found;
        unique case (r_state)
            S_LOAD: begin
                if (i_start) begin
                    n_lo    = '0;
                    n_hi    = IW'(i_count) - IW'(1);
                    n_count = i_count;
                    n_where = '0;
                    n_found = 1'b0;
                end
            end
            S_CHECK: begin
                o_raddr = r_lo[AW-1:0];
            end
            S_RD_HI: begin
                o_raddr = r_hi[AW-1:0];
                n_vlo   = w_rd;
            end
            S_ENDS: begin
                o_raddr = w_mid;
                n_vhi   = w_rd;
                n_mid   = w_mid;
                if (w_ends_ok) begin
                    n_where = r_lo[AW-1:0];
                    n_found = 1'b1;
                end
            end
            S_RD_NXT: begin
                o_raddr = w_nxt;
                n_vm    = w_rd;
            end
            S_RD_PRV: begin
                o_raddr = w_prv;
                n_vn    = w_rd;
            end
            S_DECIDE: begin
                priority if (w_is_pivot) begin
                    n_where = r_mid;
                    n_found = 1'b1;
                end else if (r_vm <= r_vhi) begin
                    n_hi = w_mid_ext - IW'(1);
                end else if (r_vm >= r_vlo) begin
                    n_lo = w_mid_ext + IW'(1);
                end else begin
                    n_found = 1'b0;
                end
            end
            S_DONE: begin
                o_raddr = r_lo[AW-1:0];
            end
            default: begin
                o_raddr = r_lo[AW-1:0];
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Search registers.
    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_count <= n_count;
        r_mid   <= n_mid;
        r_vlo   <= n_vlo;
        r_vhi   <= n_vhi;
        r_vm    <= n_vm;
        r_vn    <= n_vn;
        r_where <= n_where;
        r_found <= n_found;
    end

    assign o_stat.busy  = (r_state != S_LOAD);
    assign o_stat.done  = (r_state == S_DONE);
    assign o_stat.found = r_found;
    assign o_where      = r_where;

endmodule

// File: design/rotated_sorted_min_search.sv
// Top level of the rotated sorted minimum search block.
// Depends on rsms_pkg, rsms_mem and rsms_search.
//
// Elements of a circularly sorted array of signed 32-bit values are loaded
// one item per cycle into a store of DEPTH entries; items beyond DEPTH are
// dropped. The item marked last is stored like the others and then starts a
// binary search for the index of the smallest element (the rotation count),
// which comes out as one result item; found is 0 when duplicates or unsorted
// data leave no pivot. While the search runs, the input is stalled. The
// search shares the store's single read port: each step reads the two ends
// of the range and, unless they are already in order, the middle and its
// two wrapped neighbors back to back, and the decision is made in the cycle
// the last of them arrives. The result then moves to the output register.
// A result held in the output register does not stop the loading of the
// next array; a second finished search waits for that register and keeps
// the input stalled.
module rotated_sorted_min_search
    import rsms_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]    r_fill;
    logic             r_out_valid;
    t_out_item        r_out_item;

    logic             w_accept;
    logic             w_has_room;
    logic             w_start;
    logic [CW-1:0]    w_count;
    logic             w_res_take;
    logic [AW-1:0]    w_raddr;
    logic [VAL_W-1:0] w_rdata;
    logic [AW-1:0]    w_where;
    t_srch_stat       w_stat;

    // Input handshake and fill tracking.
    assign o_in_stall = w_stat.busy;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_has_room = (r_fill < CW'(DEPTH));
    assign w_start    = w_accept && i_in_item.last;
    assign w_count    = w_has_room ? r_fill + CW'(1) : r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (w_accept) begin
            if (i_in_item.last) begin
                r_fill <= '0;
            end else if (w_has_room) begin
                r_fill <= r_fill + CW'(1);
            end
        end
    end

    // Value store.
    rsms_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_accept && w_has_room),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (i_in_item.elem_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Search sequencer.
    rsms_search #(
        .DEPTH (DEPTH)
    ) u_search (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_count    (w_count),
        .i_res_take (w_res_take),
        .i_rdata    (w_rdata),
        .o_raddr    (w_raddr),
        .o_stat     (w_stat),
        .o_where    (w_where)
    );

    // Output register; a finished search moves in when the slot is free or is emptied in the same cycle.
    assign w_res_take = w_stat.done && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_out_item.rotation <= ROT_W'(w_where);
            r_out_item.found    <= w_stat.found;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
